// ===== rtl/core/mex_pkg.sv =====
// Shared types and codes for the modular exponentiation core.
// Used by mex_ctrl, mex_datapath and the top level; depends on nothing.
package mex_pkg;

	// operand selection for the shared modular multiplier
	localparam logic [1:0] SEL_REDUCE = 2'd0;  // base mod m: add one per set base bit
	localparam logic [1:0] SEL_SQUARE = 2'd1;  // w * w mod m
	localparam logic [1:0] SEL_MULT   = 2'd2;  // w * base mod m

	typedef struct packed {
		logic       load;       // capture a new request
		logic       mul_start;  // launch the multiplier
		logic [1:0] mul_sel;    // operand selection for the launch
		logic       wb_base;    // write multiplier result to reduced base
		logic       wb_w;       // write multiplier result to working value
		logic       exp_shift;  // advance to next exponent bit
		logic       out_load;   // capture the result into the output register
	} mex_cmd_t;

	typedef struct packed {
		logic mul_done;     // multiplier result ready this cycle
		logic exp_msb;      // current exponent bit
		logic exp_last;     // current exponent bit is bit 0
		logic mod_zero_in;  // modulus of the offered request is zero
	} mex_status_t;

endpackage

// ===== rtl/core/mex_datapath.sv =====
// Datapath: operand registers, exponent shifter and a bit-serial modular multiplier.
// Depends on mex_pkg for the command and status structs.
module mex_datapath import mex_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mex_cmd_t    cmd,
	output mex_status_t status,
	input  logic [31:0] base_value,
	input  logic [31:0] exponent_value,
	input  logic [31:0] modulus_value,
	output logic [31:0] power_result
);

	localparam int CW = $clog2(WIDTH);
	localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

	logic [WIDTH-1:0] base_in, exp_in, mod_in;
	logic [WIDTH-1:0] m_q, base_q, w_q, exp_q;
	logic [WIDTH-1:0] mul_a_q, mul_b_q, acc_q;
	logic [CW-1:0]    mul_cnt_q, exp_cnt_q;
	logic             mul_busy_q, mul_done_q;
	logic [31:0]      result_q;

	logic [WIDTH-1:0] one_mod;
	logic [WIDTH:0]   dbl, sum;
	logic [WIDTH+1:0] dbl_diff, sum_diff;
	logic [WIDTH-1:0] dbl_mod, acc_next;

	assign base_in = WIDTH'(base_value);
	assign exp_in  = WIDTH'(exponent_value);
	assign mod_in  = WIDTH'(modulus_value);

	assign one_mod = (m_q == WIDTH'(1)) ? '0 : WIDTH'(1);

	// one multiplier step: acc = 2*acc mod m, then add a mod m when the bit is set
	always_comb begin
		dbl      = {acc_q, 1'b0};
		dbl_diff = {1'b0, dbl} - {2'b00, m_q};
		dbl_mod  = dbl_diff[WIDTH+1] ? dbl[WIDTH-1:0] : dbl_diff[WIDTH-1:0];
		sum      = {1'b0, dbl_mod} + {1'b0, mul_a_q};
		sum_diff = {1'b0, sum} - {2'b00, m_q};
		if (mul_b_q[WIDTH-1]) begin
			acc_next = sum_diff[WIDTH+1] ? sum[WIDTH-1:0] : sum_diff[WIDTH-1:0];
		end else begin
			acc_next = dbl_mod;
		end
	end

	// multiplier control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mul_cnt_q  <= '0;
			exp_cnt_q  <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (cmd.mul_start) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q  <= '0;
			end else if (mul_busy_q) begin
				mul_cnt_q <= mul_cnt_q + CW'(1);
				if (mul_cnt_q == LAST) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				exp_cnt_q <= '0;
			end else if (cmd.exp_shift) begin
				exp_cnt_q <= exp_cnt_q + CW'(1);
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= mod_in;
			base_q <= base_in;
			exp_q  <= exp_in;
			w_q    <= (mod_in > WIDTH'(1)) ? WIDTH'(1) : '0;
		end else begin
			if (cmd.wb_base) begin
				base_q <= acc_q;
			end
			if (cmd.wb_w) begin
				w_q <= acc_q;
			end
			if (cmd.exp_shift) begin
				exp_q <= {exp_q[WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.mul_start) begin
			acc_q <= '0;
			unique case (cmd.mul_sel)
				SEL_REDUCE: begin
					mul_a_q <= one_mod;
					mul_b_q <= base_q;
				end
				SEL_SQUARE: begin
					mul_a_q <= w_q;
					mul_b_q <= w_q;
				end
				SEL_MULT: begin
					mul_a_q <= w_q;
					mul_b_q <= base_q;
				end
				default: begin
					mul_a_q <= w_q;
					mul_b_q <= w_q;
				end
			endcase
		end else if (mul_busy_q) begin
			acc_q   <= acc_next;
			mul_b_q <= {mul_b_q[WIDTH-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			result_q <= 32'(w_q);
		end
	end

	assign status.mul_done    = mul_done_q;
	assign status.exp_msb     = exp_q[WIDTH-1];
	assign status.exp_last    = (exp_cnt_q == LAST);
	assign status.mod_zero_in = (mod_in == '0);
	assign power_result       = result_q;

endmodule

// ===== rtl/core/mex_ctrl.sv =====
// Controller: sequences base reduction, squarings and multiplications per request.
// Depends on mex_pkg for the command and status structs.
module mex_ctrl import mex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  mex_status_t status,
	output mex_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RED   = 3'd1;
	localparam logic [2:0] S_RED_W = 3'd2;
	localparam logic [2:0] S_SQ    = 3'd3;
	localparam logic [2:0] S_SQ_W  = 3'd4;
	localparam logic [2:0] S_MU    = 3'd5;
	localparam logic [2:0] S_MU_W  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					// zero modulus: working value is already zero
					state_d  = status.mod_zero_in ? S_FIN : S_RED;
				end
			end
			S_RED: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = SEL_REDUCE;
				state_d       = S_RED_W;
			end
			S_RED_W: begin
				if (status.mul_done) begin
					cmd.wb_base = 1'b1;
					state_d     = S_SQ;
				end
			end
			S_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = SEL_SQUARE;
				state_d       = S_SQ_W;
			end
			S_SQ_W: begin
				if (status.mul_done) begin
					cmd.wb_w = 1'b1;
					if (status.exp_msb) begin
						state_d = S_MU;
					end else if (status.exp_last) begin
						state_d = S_FIN;
					end else begin
						cmd.exp_shift = 1'b1;
						state_d       = S_SQ;
					end
				end
			end
			S_MU: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = SEL_MULT;
				state_d       = S_MU_W;
			end
			S_MU_W: begin
				if (status.mul_done) begin
					cmd.wb_w = 1'b1;
					if (status.exp_last) begin
						state_d = S_FIN;
					end else begin
						cmd.exp_shift = 1'b1;
						state_d       = S_SQ;
					end
				end
			end
			S_FIN: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/modular_exponentiation_core.sv =====
// Top level of the modular exponentiation core: controller plus datapath.
// Depends on mex_pkg, mex_ctrl and mex_datapath.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   base_value, exponent_value, modulus_value
//   out      result     out_valid / out_stall power_result
//
// One request runs a base reduction, then for each of the WIDTH exponent bits a squaring,
// plus a multiplication for every set bit, framed by an accept state and a finish state;
// all of these share the one bit-serial modular multiplier, and no new request is taken
// until the last one leaves the finish state. A zero modulus goes straight from the
// accept state to the finish state.
// Reset clears the controller and the multiplier control; no request is in flight.
// A new request is taken while a result waits in the output register; out_stall only
// holds the finish of the following request.
module modular_exponentiation_core import mex_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] base_value,
	input  logic [31:0] exponent_value,
	input  logic [31:0] modulus_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] power_result
);

	mex_cmd_t    cmd;
	mex_status_t status;

	mex_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mex_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus_value  (modulus_value),
		.power_result   (power_result)
	);

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for modular_exponentiation_core: directed corner requests,
// then random requests with bursty input and patterned output stall.
// Depends on the RTL (mex_pkg, controller, datapath, top level) only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIRECTED_COUNT = 22;
	localparam int RANDOM_COUNT   = 250;
	// covers one full worst-case request plus the longest output stall and input gap
	localparam int IDLE_LIMIT     = 40000;
	localparam int DRAIN_CYCLES   = 200;

	typedef struct packed {
		logic [31:0] base_v;
		logic [31:0] expo;
		logic [31:0] modulus;
		logic [31:0] power;
	} power_case_t;

	class power_scoreboard;
		power_case_t pending_powers[$];
		int requests, compared, errors;
		int zero_mod, zero_exp, unreduced_base;

		// left-to-right square and multiply with exact 64-bit products
		function logic [31:0] predict_power(logic [31:0] b, logic [31:0] e, logic [31:0] m);
			longint unsigned acc, red_base, modw;
			if (m == 0)
				return 32'd0;
			modw = m;
			acc = 64'd1 % modw;
			red_base = b % modw;
			for (int i = 31; i >= 0; i--) begin
				acc = (acc * acc) % modw;
				if (e[i])
					acc = (acc * red_base) % modw;
			end
			return acc[31:0];
		endfunction

		function void note_request(logic [31:0] b, logic [31:0] e, logic [31:0] m);
			power_case_t pc;
			pc.base_v = b;
			pc.expo = e;
			pc.modulus = m;
			pc.power = predict_power(b, e, m);
			pending_powers.push_back(pc);
			requests++;
			if (m == 0)
				zero_mod++;
			if (e == 0)
				zero_exp++;
			if (m != 0 && b >= m)
				unreduced_base++;
		endfunction

		function void check_power(logic [31:0] got);
			power_case_t pc;
			if (pending_powers.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] unexpected result %h with no request pending", $time, got);
				return;
			end
			pc = pending_powers.pop_front();
			compared++;
			if (got !== pc.power) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] power_result mismatch: base=%h exp=%h mod=%h expected %h got %h",
						$time, pc.base_v, pc.expo, pc.modulus, pc.power, got);
			end
		endfunction

		function int waiting();
			return pending_powers.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] base_value = '0;
	logic [31:0] exponent_value = '0;
	logic [31:0] modulus_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] power_result;

	power_scoreboard sb = new();
	int burst_left = 0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	modular_exponentiation_core #(.WIDTH(32)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.base_value(base_value),
		.exponent_value(exponent_value),
		.modulus_value(modulus_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.power_result(power_result)
	);

	// sample both channels at the edge; outputs settle after the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(base_value, exponent_value, modulus_value);
			if (out_valid && !out_stall)
				sb.check_power(power_result);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] timeout: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern: free running, random, heavy, or one long hold
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		int r;
		if (stall_left == 0) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				stall_mode = 0;
				stall_left = $urandom_range(50, 600);
			end else if (r < 75) begin
				stall_mode = 1;
				stall_left = $urandom_range(50, 600);
			end else if (r < 97) begin
				stall_mode = 2;
				stall_left = $urandom_range(20, 200);
			end else begin
				stall_mode = 3;
				stall_left = $urandom_range(200, 2000);
			end
		end
		stall_left = stall_left - 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 9) != 0);
			default: out_stall <= 1'b1;
		endcase
	end

	// offer one request; drop valid only when a gap is due
	task automatic issue_request(logic [31:0] b, logic [31:0] e, logic [31:0] m);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2500) : $urandom_range(0, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		base_value <= b;
		exponent_value <= e;
		modulus_value <= m;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	task automatic make_random_request(output logic [31:0] b, output logic [31:0] e,
			output logic [31:0] m);
		int kind;
		kind = $urandom_range(0, 99);
		b = $urandom;
		e = $urandom;
		m = $urandom;
		if (kind < 35) begin
			// full random operands
		end else if (kind < 55) begin
			m = $urandom_range(1, 1000);
		end else if (kind < 63) begin
			m = $urandom_range(0, 1);
			e = $urandom_range(0, 3) == 0 ? 32'd0 : e;
		end else if (kind < 78) begin
			// base well above a smaller modulus
			m = $urandom >> $urandom_range(1, 24);
			b = b | 32'h8000_0000;
		end else if (kind < 90) begin
			// near-full modulus stresses the widest products
			m = $urandom | 32'hC000_0000;
			e = e >> $urandom_range(0, 31);
		end else begin
			e = $urandom_range(0, 3) == 0 ? 32'd0 : ($urandom_range(0, 15));
		end
	endtask

	logic [31:0] directed_base [DIRECTED_COUNT] = '{
		32'h0, 32'hFFFF_FFFF, 32'd5, 32'd7, 32'd7, 32'h0, 32'h0, 32'hFFFF_FFFF,
		32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd2, 32'd3, 32'd100, 32'd12345, 32'd2,
		32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1, 32'd6,
		32'hFFFF_FFFF};
	logic [31:0] directed_expo [DIRECTED_COUNT] = '{
		32'h0, 32'hFFFF_FFFF, 32'd3, 32'h0, 32'h0, 32'h0, 32'd5, 32'hFFFF_FFFF,
		32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd31, 32'hFFFF_FFFF, 32'd1, 32'd65537, 32'd10,
		32'd2, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd1,
		32'd1};
	logic [31:0] directed_mod [DIRECTED_COUNT] = '{
		32'h0, 32'h0, 32'd1, 32'd13, 32'd1, 32'hFFFF_FFFF, 32'd97, 32'hFFFF_FFFF,
		32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'd7, 32'h8000_0000,
		32'd1000, 32'd2, 32'hFFFF_FFFF, 32'hAAAA_AAAB, 32'h5555_5555, 32'd3, 32'd7,
		32'hFFFF_FFFF};

	initial begin
		logic [31:0] b, e, m;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_COUNT; i++)
			issue_request(directed_base[i], directed_expo[i], directed_mod[i]);
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			make_random_request(b, e, m);
			issue_request(b, e, m);
		end
		in_valid <= 1'b0;
		while (sb.waiting() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests: %0d zero modulus, %0d zero exponent, %0d base >= modulus",
			sb.requests, sb.zero_mod, sb.zero_exp, sb.unreduced_base);
		$display("Compared %0d results, %0d errors", sb.compared, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mex_pkg.sv
rtl/core/mex_datapath.sv
rtl/core/mex_ctrl.sv
rtl/core/modular_exponentiation_core.sv
bench/tb.sv
